// File: rtl/sacc_pkg.sv
// Shared types, sizes and helpers for the subarray AND-equal counter.
// Used by sacc_cell, sacc_merge and subarray_and_equal_counter_core.
`default_nettype none

package sacc_pkg;

  localparam int WORD_BITS   = 32;
  localparam int CNT_BITS    = 48;
  localparam int TABLE_DEPTH = 33;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  // One table entry: an AND value and how many start positions give it.
  typedef struct packed {
    logic                 vld;
    logic [WORD_BITS-1:0] val;
    logic [CNT_BITS-1:0]  cnt;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic init;
    logic step;
  } merge_ctrl_t;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/sacc_cell.sv
// One table cell: holds an entry, takes its neighbor's entry on a shift,
// or a write-back entry on a load. Depends on sacc_pkg.
`default_nettype none

module sacc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sacc_pkg::cell_ctrl_t ctrl_i,
  input  sacc_pkg::entry_t    load_i,
  input  sacc_pkg::entry_t    next_i,
  output sacc_pkg::entry_t    cell_o
);
  import sacc_pkg::*;

  logic                 vld_q, vld_d;
  logic [WORD_BITS-1:0] val_q, val_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    cnt_d = cnt_q;
    if (ctrl_i.clr) begin
      vld_d = 1'b0;
    end else if (ctrl_i.load) begin
      vld_d = load_i.vld;
      val_d = load_i.val;
      cnt_d = load_i.cnt;
    end else if (ctrl_i.shift) begin
      vld_d = next_i.vld;
      val_d = next_i.val;
      cnt_d = next_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
  end

  assign cell_o = '{vld: vld_q, val: val_q, cnt: cnt_q};

endmodule

`default_nettype wire

// File: rtl/sacc_merge.sv
// Merge stage at the head of the cell row: ANDs each popped entry with the
// word, folds equal neighbors into a pending group. Depends on sacc_pkg.
`default_nettype none

module sacc_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sacc_pkg::merge_ctrl_t     ctrl_i,
  input  logic [sacc_pkg::WORD_BITS-1:0] word_i,
  input  logic [sacc_pkg::WORD_BITS-1:0] target_i,
  input  sacc_pkg::entry_t          head_i,
  output logic                      emit_o,
  output sacc_pkg::entry_t          pend_o
);
  import sacc_pkg::*;

  entry_t               pend_q, pend_d;
  logic [WORD_BITS-1:0] anded;
  logic                 item_ok;
  logic                 same;

  // Table is kept in descending order, so equal AND results are adjacent.
  assign anded   = head_i.val & word_i;
  assign item_ok = head_i.vld && (anded >= target_i);
  assign same    = pend_q.vld && (anded == pend_q.val);
  assign emit_o  = ctrl_i.step && item_ok && !same;

  always_comb begin
    pend_d = pend_q;
    if (ctrl_i.init) begin
      pend_d.vld = (word_i >= target_i);
      pend_d.val = word_i;
      pend_d.cnt = CNT_BITS'(1);
    end else if (ctrl_i.step && item_ok) begin
      if (same) begin
        pend_d.cnt = sat_add(pend_q.cnt, head_i.cnt);
      end else begin
        pend_d.vld = 1'b1;
        pend_d.val = anded;
        pend_d.cnt = head_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  assign pend_o = pend_q;

endmodule

`default_nettype wire

// File: rtl/subarray_and_equal_counter_core.sv
// Counts subarrays whose bitwise AND equals a target, over a word stream.
// A row of table cells shifts through a merge stage at its head; the
// block's control and result register live here. Depends on sacc_pkg,
// sacc_cell and sacc_merge.
//
// Usage: input words arrive on in_valid_i / in_stall_o with word_i and
// first_i; first_i set restarts the array (table and total cleared). Each
// word yields one word on out_valid_o / out_stall_i carrying match_total_o,
// the saturating running count. The target must be written over cfg_valid_i /
// cfg_ready_o only while the block is idle; the block itself does not enforce it.
// After a word is taken, the sweep streams the 33-entry cell row through the
// merge stage, then the flush writes back the last group and loads the result
// register. A new word is taken only once the block is back in idle, so a word
// is never taken before the previous one has been through the flush.
// A waiting result sits in the output register; the next word is still taken,
// and its write-back holds until the receiver stops stalling.
// Reset empties the table, zeroes the total and target, drops any result.
`default_nettype none

module subarray_and_equal_counter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sacc_pkg::WORD_BITS-1:0] word_i,
  input  logic                           first_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sacc_pkg::CNT_BITS-1:0]  match_total_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sacc_pkg::WORD_BITS-1:0] cfg_target_value_i
);
  import sacc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FLUSH
  } state_e;

  state_e               state_q;
  logic [WORD_BITS-1:0] target_q;
  logic [WORD_BITS-1:0] word_q;
  logic [IDX_W-1:0]     step_q;
  logic [IDX_W-1:0]     dest_q;
  logic [FILL_W-1:0]    fill_q;
  logic [CNT_BITS-1:0]  total_q;
  logic                 out_valid_q;
  logic [CNT_BITS-1:0]  out_total_q;

  logic                 accept;
  logic                 flush_go;
  logic                 fill_ok;
  logic                 emit;
  logic [WORD_BITS-1:0] merge_word;
  entry_t               pend;
  entry_t               cells [TABLE_DEPTH];
  entry_t               load_entry;
  merge_ctrl_t          mctrl;
  logic [TABLE_DEPTH-1:0] load_vec;
  logic [CNT_BITS-1:0]  total_d;

  assign in_stall_o    = (state_q != S_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign match_total_o = out_total_q;

  assign flush_go = (state_q == S_FLUSH) && (!out_valid_q || !out_stall_i);
  assign fill_ok  = (fill_q < FILL_W'(TABLE_DEPTH));

  assign mctrl.init = accept;
  assign mctrl.step = (state_q == S_SWEEP);

  // The pending group is seeded from the incoming word before word_q loads.
  assign merge_word = accept ? word_i : word_q;

  sacc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mctrl),
    .word_i   (merge_word),
    .target_i (target_q),
    .head_i   (cells[0]),
    .emit_o   (emit),
    .pend_o   (pend)
  );

  // Emitted groups land at dest_q, chosen so that after the remaining shifts
  // group j sits in cell j; the last group is written at fill_q unshifted.
  assign load_entry = pend;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_vec[i] = (mctrl.step && emit && (dest_q == IDX_W'(i))) ||
                    (flush_go && pend.vld && fill_ok && (fill_q == FILL_W'(i)));
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t     nxt;
    cell_ctrl_t cctrl;

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_body
      assign nxt = cells[g+1];
    end

    assign cctrl.clr   = accept && first_i;
    assign cctrl.shift = mctrl.step;
    assign cctrl.load  = load_vec[g];

    sacc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cctrl),
      .load_i (load_entry),
      .next_i (nxt),
      .cell_o (cells[g])
    );
  end

  // Only the last (smallest) group can equal the target.
  always_comb begin
    total_d = total_q;
    if (pend.vld && (pend.val == target_q)) begin
      total_d = sat_add(total_q, pend.cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= '0;
      word_q      <= '0;
      step_q      <= '0;
      dest_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_total_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        target_q <= cfg_target_value_i;
      end
      if (out_valid_q && !out_stall_i && !flush_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            word_q  <= word_i;
            step_q  <= '0;
            dest_q  <= IDX_W'(TABLE_DEPTH - 1);
            fill_q  <= '0;
            if (first_i) begin
              total_q <= '0;
            end
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          dest_q <= dest_q + IDX_W'(emit) - IDX_W'(1);
          fill_q <= fill_q + FILL_W'(emit);
          step_q <= step_q + IDX_W'(1);
          if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (flush_go) begin
            total_q     <= total_d;
            out_total_q <= total_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: test/tb_subarray_and_equal_counter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for subarray_and_equal_counter_core: a directed table, then
// random words under three idle mixes, checked against a cycle-free AND-table predictor.
// Depends on sacc_pkg and the core RTL only.

module tb_subarray_and_equal_counter_core;

  localparam int WB         = sacc_pkg::WORD_BITS;
  localparam int CB         = sacc_pkg::CNT_BITS;
  localparam int DEPTH      = sacc_pkg::TABLE_DEPTH;
  localparam int QUIET_MAX  = 3000;
  localparam int RAND_WORDS = 300;  // per idle mix

  localparam logic [CB-1:0] TOTAL_CAP = {CB{1'b1}};
  localparam logic [WB-1:0] ONES      = {WB{1'b1}};

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [WB-1:0] word_i = '0;
  logic          first_i = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [CB-1:0] match_total_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [WB-1:0] cfg_target_value_i = '0;

  always #5 clk_i = ~clk_i;

  subarray_and_equal_counter_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .word_i             (word_i),
    .first_i            (first_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .match_total_o      (match_total_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_target_value_i (cfg_target_value_i)
  );

  // Predictor state: AND values of subarrays ending at the last word, with start counts.
  logic [WB-1:0] and_val [DEPTH];
  logic [CB-1:0] and_starts [DEPTH];
  logic          and_used [DEPTH];
  logic [WB-1:0] nxt_val [DEPTH];
  logic [CB-1:0] nxt_starts [DEPTH];
  logic          nxt_used [DEPTH];
  logic [WB-1:0] target_k = '0;
  logic [CB-1:0] total_so_far = '0;

  logic [CB-1:0] pending_totals [$];
  logic [CB-1:0] want_total;

  int snd_idle_pct = 14;
  int rcv_idle_pct = 73;
  int n_errors = 0;
  int n_words = 0;
  int n_checked = 0;
  int n_nonzero = 0;
  int n_targets = 0;
  int quiet_cycles = 0;

  function automatic logic [CB-1:0] add_capped(input logic [CB-1:0] a, input logic [CB-1:0] b);
    if (a > TOTAL_CAP - b) return TOTAL_CAP;
    return a + b;
  endfunction

  // Merge a value into the next table; a value with no free slot is lost.
  function automatic void fold_in(input logic [WB-1:0] v, input logic [CB-1:0] c);
    int slot;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (nxt_used[i]) begin
        if (nxt_val[i] == v) begin
          nxt_starts[i] = add_capped(nxt_starts[i], c);
          return;
        end
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (slot >= 0) begin
      nxt_val[slot]    = v;
      nxt_starts[slot] = c;
      nxt_used[slot]   = 1'b1;
    end
  endfunction

  function automatic logic [CB-1:0] predict_match_total(input logic [WB-1:0] w, input logic f);
    logic [WB-1:0] v;
    if (f) begin
      for (int i = 0; i < DEPTH; i++) and_used[i] = 1'b0;
      total_so_far = '0;
    end
    for (int i = 0; i < DEPTH; i++) nxt_used[i] = 1'b0;
    if (w >= target_k) fold_in(w, CB'(1));
    for (int i = 0; i < DEPTH; i++) begin
      v = and_val[i] & w;
      // values below k never climb back to k under AND
      if (and_used[i] && v >= target_k) fold_in(v, and_starts[i]);
    end
    for (int i = 0; i < DEPTH; i++)
      if (nxt_used[i] && nxt_val[i] == target_k)
        total_so_far = add_capped(total_so_far, nxt_starts[i]);
    and_val    = nxt_val;
    and_starts = nxt_starts;
    and_used   = nxt_used;
    return total_so_far;
  endfunction

  task automatic report_mismatch(input string what, input logic [CB-1:0] want,
                                 input logic [CB-1:0] got);
    $display("%0t mismatch: %s, expected %0d got %0d", $realtime, what, want, got);
    n_errors++;
  endtask

  // Present one word, wait for it to be taken, queue the total it must produce.
  task automatic send_word(input logic [WB-1:0] w, input logic f, input logic typed,
                           input logic [CB-1:0] want);
    logic [CB-1:0] predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_i     <= w;
    first_i    <= f;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_match_total(w, f);
    pending_totals = {pending_totals, (typed ? want : predicted)};
    n_words++;
  endtask

  // Target is only written with the block drained.
  task automatic set_target(input logic [WB-1:0] k);
    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_target_value_i <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    target_k = k;
    n_targets++;
  endtask

  function automatic logic [WB-1:0] pick_target();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ONES;
      2:       return $urandom();
      default: return $urandom() & $urandom() & $urandom();
    endcase
  endfunction

  // Mostly supersets of k so that runs of ANDs land on k; some noise.
  function automatic logic [WB-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom();
    if (r < 18) return target_k;
    if (r < 80) return target_k | ($urandom() & $urandom() & $urandom());
    return target_k | $urandom();
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    if (out_valid_o && !out_stall_i) begin
      if (pending_totals.size() == 0) begin
        report_mismatch("total with no word pending", '0, match_total_o);
      end else begin
        want_total = pending_totals.pop_front();
        if (match_total_o !== want_total) report_mismatch("match_total", want_total, match_total_o);
        n_checked++;
        if (want_total != 0) n_nonzero++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout: no handshake for %0d cycles", QUIET_MAX);
      $display("FAIL subarray_and_equal_counter_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  typedef struct {
    logic          set_k;
    logic [WB-1:0] k;
    logic [WB-1:0] w;
    logic          f;
    logic          typed;
    logic [CB-1:0] want;
  } dir_row_t;

  // set_k writes k before the row; typed rows carry a hand-computed total.
  dir_row_t dir_rows [24] = '{
    // k = 0 from reset, no first flag yet
    '{1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 48'd1},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 48'd2},
    '{1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 48'd0},
    '{1'b0, 32'h0000_0000, 32'h0000_FFFF, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0000_0000, 32'hFFFF_0000, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 48'd0},
    // k all ones: anything below is dropped
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 48'd1},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 48'd3},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 1'b1, 48'd3},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 48'd4},
    '{1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, 48'd4},
    // k = lsb only
    '{1'b1, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 48'd1},
    '{1'b0, 32'h0000_0001, 32'h0000_0003, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'd0},
    // k = msb only, unsigned compare
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 48'd1},
    '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 48'd1},
    '{1'b0, 32'h8000_0000, 32'hC000_0000, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h8000_0000, 32'h8000_0001, 1'b0, 1'b0, 48'd0},
    // mixed k
    '{1'b1, 32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b1, 1'b1, 48'd1},
    '{1'b0, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b0, 1'b0, 48'd0},
    '{1'b0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, 1'b0, 48'd0}
  };

  initial begin
    int left;
    int seg;
    logic f;
    for (int i = 0; i < DEPTH; i++) and_used[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_k) set_target(dir_rows[i].k);
      send_word(dir_rows[i].w, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      snd_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 73 : 0;
      rcv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 14 : 0;
      left = RAND_WORDS;
      while (left > 0) begin
        seg = $urandom_range(20, 60);
        if (seg > left) seg = left;
        if ($urandom_range(99) < 60) set_target(pick_target());
        for (int j = 0; j < seg; j++) begin
          f = (j == 0) ? ($urandom_range(99) < 70) : ($urandom_range(99) < 2);
          send_word(pick_word(), f, 1'b0, '0);
        end
        left -= seg;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_totals.size() != 0) report_mismatch("totals never delivered", '0, '0);

    $display("run: %0d words sent, %0d totals checked (%0d nonzero), %0d target writes",
             n_words, n_checked, n_nonzero, n_targets);
    $display("idle mixes 14/73, 73/14 and none; %0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("PASS subarray_and_equal_counter_core");
    end else begin
      $display("FAIL subarray_and_equal_counter_core");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sacc_pkg.sv
rtl/sacc_cell.sv
rtl/sacc_merge.sv
rtl/subarray_and_equal_counter_core.sv
test/tb_subarray_and_equal_counter_core.sv
